// File: rtl/scfp_pkg.sv
`default_nettype none
package scfp_pkg;

  // frame layout
  localparam int unsigned DataBytes  = 8;
  localparam int unsigned FrameBytes = 10;
  localparam int unsigned CntW       = 4;

  // crc-16/modbus, reflected form
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  // one input item: four channel samples
  typedef struct packed {
    logic signed [15:0] sample_ch1;
    logic signed [15:0] sample_ch2;
    logic signed [15:0] sample_ch3;
    logic signed [15:0] sample_ch4;
  } sample_in_t;

  // one result item: a frame byte
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } frame_out_t;

  // fold one byte into the crc, lsb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: rtl/scope_frame_crc16_packer.sv
`default_nettype none
// Frame packer: an item (four 16-bit samples) is taken when start is high and busy
// is low, and comes out as a 10-byte frame, one byte per cycle on result_valid_o:
// the eight sample bytes (channel 1 to 4, low byte first), then the CRC-16/MODBUS
// of those bytes, low byte first; frame_end marks the tenth byte. The CRC runs
// through an eight-stage pipeline, one data byte per stage; the serializer loads a
// frame when its item leaves the last stage. The byte serializer sets the sustained
// rate, and frames leave back to back with no gap while the next item is waiting in
// the last stage. Up to eight further items may be held in the pipeline while a
// frame is being sent; busy rises only when the pipeline is full. The receiver cannot
// stall: each byte is shown for exactly one cycle and must be taken then.
module scope_frame_crc16_packer (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     start,
  output logic                    busy,
  input  scfp_pkg::sample_in_t    sample_i,
  output logic                    result_valid_o,
  output scfp_pkg::frame_out_t    result_o
);
  import scfp_pkg::*;

  localparam int unsigned NumStages = DataBytes;
  localparam logic [CntW-1:0] LastIdx = CntW'(FrameBytes - 1);

  // pipeline registers, one byte of crc per stage
  logic [NumStages-1:0] v_q;
  logic [63:0]          smp_q [NumStages];
  logic [15:0]          crc_q [NumStages];
  logic [NumStages:0]   en;

  // serializer
  logic                 ser_act_q, ser_act_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [79:0]          sh_q, sh_d;
  logic                 ser_done;
  logic                 load;
  logic                 in_xfer;
  logic [63:0]          smp_in;

  assign smp_in = {sample_i.sample_ch4, sample_i.sample_ch3,
                   sample_i.sample_ch2, sample_i.sample_ch1};

  // hand over to the serializer when idle or on the last byte of a frame
  assign ser_done = ser_act_q && (cnt_q == LastIdx);
  assign load     = v_q[NumStages-1] && (!ser_act_q || ser_done);

  // a stage may take new data when empty or when its content moves on
  always_comb begin
    en[NumStages] = load;
    for (int k = NumStages - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign busy    = !en[0];
  assign in_xfer = start && !busy;

  // crc pipeline stages
  for (genvar k = 0; k < NumStages; k++) begin : g_stage
    logic        v_src;
    logic [63:0] smp_src;
    logic [15:0] crc_src;

    if (k == 0) begin : g_first
      assign v_src   = in_xfer;
      assign smp_src = smp_in;
      assign crc_src = CrcInit;
    end else begin : g_next
      assign v_src   = v_q[k-1];
      assign smp_src = smp_q[k-1];
      assign crc_src = crc_q[k-1];
    end

    // valid bit
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= v_src;
      end
    end

    // payload
    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        smp_q[k] <= smp_src;
        crc_q[k] <= crc_byte(crc_src, smp_src[8*k +: 8]);
      end
    end
  end

  // serializer next state
  always_comb begin
    ser_act_d = ser_act_q;
    cnt_d     = cnt_q;
    sh_d      = sh_q;
    if (load) begin
      ser_act_d = 1'b1;
      cnt_d     = '0;
      sh_d      = {crc_q[NumStages-1], smp_q[NumStages-1]};
    end else if (ser_act_q) begin
      sh_d = {8'h00, sh_q[79:8]};
      if (ser_done) begin
        ser_act_d = 1'b0;
        cnt_d     = '0;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  // serializer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_act_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      ser_act_q <= ser_act_d;
      cnt_q     <= cnt_d;
    end
  end

  // frame shift register
  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
  end

  // result ports
  assign result_valid_o      = ser_act_q;
  assign result_o.frame_byte = sh_q[7:0];
  assign result_o.frame_end  = ser_done;

endmodule
`default_nettype wire
